@@ sv/tfn_pkg.sv @@
// ----------------------------------------------------------------------------
// tfn_pkg: triangle face normal shared definitions
// Payload structs, datapath widths and the per-item sideband that travels
// down the normalising pipeline.
// ----------------------------------------------------------------------------
package tfn_pkg;

  // Field widths
  localparam int CB  = 24;          // vertex coordinate
  localparam int FB  = 14;          // normal fraction bits
  localparam int OB  = FB + 2;      // normal component
  // Datapath widths
  localparam int EB  = CB + 1;      // edge
  localparam int PB  = 2 * EB;      // edge product
  localparam int XB  = PB + 1;      // cross component, signed
  localparam int MB  = PB;          // cross magnitude
  localparam int LZW = $clog2(MB);  // leading zero count
  localparam int NB  = 30;          // normalised magnitude
  localparam int SB  = 2 * NB + 2;  // sum of squares
  localparam int RB  = NB + 1;      // square root
  localparam int RW  = RB + 2;      // square root remainder
  localparam int QB  = FB + 1;      // quotient magnitude
  localparam int DW  = NB + FB + 2; // dividend

  typedef struct packed {
    logic signed [CB-1:0] a_x;
    logic signed [CB-1:0] a_y;
    logic signed [CB-1:0] a_z;
    logic signed [CB-1:0] b_x;
    logic signed [CB-1:0] b_y;
    logic signed [CB-1:0] b_z;
    logic signed [CB-1:0] c_x;
    logic signed [CB-1:0] c_y;
    logic signed [CB-1:0] c_z;
  } tfn_in_t;

  typedef struct packed {
    logic signed [OB-1:0] normal_x;
    logic signed [OB-1:0] normal_y;
    logic signed [OB-1:0] normal_z;
    logic                 degenerate;
  } tfn_out_t;

  // Per-item sideband carried alongside the arithmetic
  typedef struct packed {
    logic                 degen;
    logic [2:0]           neg;
    logic [2:0][NB-1:0]   v;
  } tfn_lane_t;

  // Pipeline control between the front end and the normaliser
  typedef struct packed {
    logic en;
    logic vld;
  } tfn_ctl_t;

endpackage

@@ sv/tfn_norm.sv @@
// ----------------------------------------------------------------------------
// tfn_norm: square root and rounding divide pipeline
// One root bit per stage, then one quotient bit per stage for the three
// components in parallel lanes.
// ----------------------------------------------------------------------------
module tfn_norm (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tfn_pkg::tfn_ctl_t         ctl,
  input  tfn_pkg::tfn_lane_t        lane,
  input  logic [tfn_pkg::SB-1:0]    sum,
  output logic                      res_vld,
  output tfn_pkg::tfn_lane_t        res_lane,
  output logic [2:0][tfn_pkg::QB-1:0] res_q
);
  import tfn_pkg::*;

  // Square root stages
  logic [RW-1:0]  rem_r  [RB+1];
  logic [RB-1:0]  root_r [RB+1];
  logic [SB-1:0]  x_r    [RB+1];
  logic           svld_r [RB+1];
  tfn_lane_t      slane_r[RB+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      svld_r[0] <= 1'b0;
    end else if (ctl.en) begin
      svld_r[0] <= ctl.vld;
    end
    if (ctl.en) begin
      rem_r[0]   <= '0;
      root_r[0]  <= '0;
      x_r[0]     <= sum;
      slane_r[0] <= lane;
    end
  end

  for (genvar j = 0; j < RB; j++) begin : g_sqrt
    logic [RW+1:0] tmp;
    logic [RW+1:0] trial;
    logic          take;
    always_comb begin
      tmp   = {rem_r[j], x_r[j][SB-1 -: 2]};
      trial = (RW+2)'({root_r[j], 2'b01});
      take  = (tmp >= trial);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        svld_r[j+1] <= 1'b0;
      end else if (ctl.en) begin
        svld_r[j+1] <= svld_r[j];
      end
      if (ctl.en) begin
        rem_r[j+1]   <= take ? RW'(tmp - trial) : RW'(tmp);
        root_r[j+1]  <= {root_r[j][RB-2:0], take};
        x_r[j+1]     <= {x_r[j][SB-3:0], 2'b00};
        slane_r[j+1] <= slane_r[j];
      end
    end
  end

  // Divide stages: q = floor((v * 2^(FB+1) + r) / (2r)), MSB first
  logic [2:0][DW-1:0] drem_r [QB+1];
  logic [2:0][QB-1:0] q_r    [QB+1];
  logic [RB:0]        dvs_r  [QB+1];
  logic               dvld_r [QB+1];
  tfn_lane_t          dlane_r[QB+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvld_r[0] <= 1'b0;
    end else if (ctl.en) begin
      dvld_r[0] <= svld_r[RB];
    end
    if (ctl.en) begin
      for (int i = 0; i < 3; i++) begin
        drem_r[0][i] <= {slane_r[RB].v[i], {(FB+1){1'b0}}} + DW'(root_r[RB]);
      end
      q_r[0]     <= '0;
      dvs_r[0]   <= {root_r[RB], 1'b0};
      dlane_r[0] <= slane_r[RB];
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int K = FB - j;
    logic [DW-1:0] dsh;
    assign dsh = DW'(dvs_r[j]) << K;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvld_r[j+1] <= 1'b0;
      end else if (ctl.en) begin
        dvld_r[j+1] <= dvld_r[j];
      end
      if (ctl.en) begin
        for (int i = 0; i < 3; i++) begin
          if (drem_r[j][i] >= dsh) begin
            drem_r[j+1][i] <= drem_r[j][i] - dsh;
            q_r[j+1][i]    <= q_r[j][i] | (QB'(1) << K);
          end else begin
            drem_r[j+1][i] <= drem_r[j][i];
            q_r[j+1][i]    <= q_r[j][i];
          end
        end
        dvs_r[j+1]   <= dvs_r[j];
        dlane_r[j+1] <= dlane_r[j];
      end
    end
  end

  assign res_vld  = dvld_r[QB];
  assign res_lane = dlane_r[QB];
  assign res_q    = q_r[QB];

`ifndef SYNTHESIS
  // A live non-degenerate item always reaches the divider with a non-zero root
  a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    svld_r[RB] && !slane_r[RB].degen |-> root_r[RB] != '0)
    else $error("non-degenerate item reached the divider with a zero root");
  // Quotient is bounded by one in Q1.FB
  a_q_range: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld && !res_lane.degen |->
      res_q[0] <= QB'(1 << FB) && res_q[1] <= QB'(1 << FB) && res_q[2] <= QB'(1 << FB))
    else $error("normal component above unit length");
  // Result valid is always known out of reset
  a_vld_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown(res_vld))
    else $error("result valid unknown");
`endif

endmodule

@@ sv/triangle_face_normal.sv @@
// ----------------------------------------------------------------------------
// triangle_face_normal: unit face normal of a triangle
// Edges, exact cross product, normalisation to signed Q1.14, rounded.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one triangle (three vertices, signed
//   24-bit). out_valid/out_ready/out_data carry its normal and a flag set for
//   a zero cross product, in which case the normal is zero.
//   Pipeline: edges, products, cross, magnitudes, leading-zero count, shift,
//   squares, sum, a loading stage, 31 square-root stages, a loading stage,
//   15 divide stages and the output register.
//   Throughput is one triangle per cycle while the output is not stalled;
//   every stage is a single register level and the pipeline advances as
//   a whole.
//   When out_ready is low with a result waiting, the whole pipeline holds and
//   in_ready drops in the same cycle; nothing is lost or repeated.
//   Reset (rst_n low, synchronous) clears all valid bits; the block is ready
//   in the first cycle after reset.
// ----------------------------------------------------------------------------
module triangle_face_normal (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tfn_pkg::tfn_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tfn_pkg::tfn_out_t out_data
);
  import tfn_pkg::*;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage 1: edges
  logic                        v1_r;
  logic signed [2:0][EB-1:0]   e_r, f_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_valid;
    if (en) begin
      e_r[0] <= EB'(in_data.b_x) - EB'(in_data.a_x);
      e_r[1] <= EB'(in_data.b_y) - EB'(in_data.a_y);
      e_r[2] <= EB'(in_data.b_z) - EB'(in_data.a_z);
      f_r[0] <= EB'(in_data.c_x) - EB'(in_data.a_x);
      f_r[1] <= EB'(in_data.c_y) - EB'(in_data.a_y);
      f_r[2] <= EB'(in_data.c_z) - EB'(in_data.a_z);
    end
  end

  // Stage 2: edge products, one pair for each cross component
  logic                  v2_r;
  logic [5:0][PB-1:0]    p_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
    if (en) begin
      p_r[0] <= $signed(e_r[1]) * $signed(f_r[2]);
      p_r[1] <= $signed(e_r[2]) * $signed(f_r[1]);
      p_r[2] <= $signed(e_r[2]) * $signed(f_r[0]);
      p_r[3] <= $signed(e_r[0]) * $signed(f_r[2]);
      p_r[4] <= $signed(e_r[0]) * $signed(f_r[1]);
      p_r[5] <= $signed(e_r[1]) * $signed(f_r[0]);
    end
  end

  // Stage 3: cross product
  logic                v3_r;
  logic [2:0][XB-1:0]  n_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n_r[i] <= XB'($signed(p_r[2*i])) - XB'($signed(p_r[2*i+1]));
      end
    end
  end

  // Stage 4: sign and magnitude, OR of magnitudes sets the bit length
  logic                v4_r;
  logic [2:0][MB-1:0]  mag4_r;
  logic [2:0]          neg4_r;
  logic [MB-1:0]       orw_r;
  logic [2:0][MB-1:0]  mag4_nxt;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag4_nxt[i] = n_r[i][XB-1] ? MB'(-n_r[i]) : MB'(n_r[i]);
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
    if (en) begin
      mag4_r <= mag4_nxt;
      for (int i = 0; i < 3; i++) neg4_r[i] <= n_r[i][XB-1];
      orw_r  <= mag4_nxt[0] | mag4_nxt[1] | mag4_nxt[2];
    end
  end

  // Stage 5: leading zero count
  logic                v5_r;
  logic [2:0][MB-1:0]  mag5_r;
  logic [2:0]          neg5_r;
  logic [LZW-1:0]      lz_r;
  logic                dg5_r;
  logic [LZW-1:0]      lz_nxt;
  always_comb begin
    lz_nxt = '0;
    for (int i = 0; i < MB; i++) begin
      if (orw_r[i]) lz_nxt = LZW'(MB - 1 - i);
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= v4_r;
    if (en) begin
      mag5_r <= mag4_r;
      neg5_r <= neg4_r;
      lz_r   <= lz_nxt;
      dg5_r  <= (orw_r == '0);
    end
  end

  // Stage 6: normalise so the largest magnitude lands in [2^29, 2^30)
  logic       v6_r;
  tfn_lane_t  ln6_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (en) v6_r <= v5_r;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ln6_r.v[i] <= NB'((mag5_r[i] << lz_r) >> (MB - NB));
      end
      ln6_r.neg   <= neg5_r;
      ln6_r.degen <= dg5_r;
    end
  end

  // Stage 7: squares
  logic                  v7_r;
  tfn_lane_t             ln7_r;
  logic [2:0][2*NB-1:0]  sq_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else if (en) v7_r <= v6_r;
    if (en) begin
      for (int i = 0; i < 3; i++) sq_r[i] <= ln6_r.v[i] * ln6_r.v[i];
      ln7_r <= ln6_r;
    end
  end

  // Stage 8: sum of squares
  logic       v8_r;
  tfn_lane_t  ln8_r;
  logic [SB-1:0] sum_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v8_r <= 1'b0;
    else if (en) v8_r <= v7_r;
    if (en) begin
      sum_r <= SB'(sq_r[0]) + SB'(sq_r[1]) + SB'(sq_r[2]);
      ln8_r <= ln7_r;
    end
  end

  // Square root and rounding divide
  tfn_ctl_t            ctl;
  logic                res_vld;
  tfn_lane_t           res_lane;
  logic [2:0][QB-1:0]  res_q;
  assign ctl.en  = en;
  assign ctl.vld = v8_r;

  tfn_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .lane     (ln8_r),
    .sum      (sum_r),
    .res_vld  (res_vld),
    .res_lane (res_lane),
    .res_q    (res_q)
  );

  // Output register: apply signs, zero for a degenerate triangle
  logic              out_vld_r;
  tfn_out_t          out_r;
  logic [2:0][OB-1:0] comp;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (res_lane.degen) comp[i] = '0;
      else if (res_lane.neg[i]) comp[i] = -OB'(res_q[i]);
      else comp[i] = OB'(res_q[i]);
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= res_vld;
    if (en) begin
      out_r.normal_x   <= comp[0];
      out_r.normal_y   <= comp[1];
      out_r.normal_z   <= comp[2];
      out_r.degenerate <= res_lane.degen;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // Degenerate flag always comes with a zero normal
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.normal_x == '0 && out_data.normal_y == '0 && out_data.normal_z == '0)
    else $error("degenerate result with a non-zero normal");
  // A real triangle never yields an all-zero normal
  a_nondegen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.degenerate |->
      out_data.normal_x != '0 || out_data.normal_y != '0 || out_data.normal_z != '0)
    else $error("non-degenerate result with a zero normal");
  // Pipeline holds while a result waits
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data) && $stable(res_q))
    else $error("pipeline moved during an output stall");
`endif

endmodule

@@ bench/tb_triangle_face_normal.sv @@
// ----------------------------------------------------------------------------
// tb_triangle_face_normal: regression bench for the face normal unit
// Streams triangles through the block under varying idle and stall patterns,
// predicts each unit normal in fixed point and checks every result in order.
// ----------------------------------------------------------------------------
class normal_scoreboard;
  tfn_pkg::tfn_out_t pending_normals[$];
  int errors;

  // Exact integer square root
  static function longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Unit normal of one triangle, rounded to nearest
  static function tfn_pkg::tfn_out_t face_normal(tfn_pkg::tfn_in_t t);
    tfn_pkg::tfn_out_t    res;
    logic signed [63:0]   ex, ey, ez, fx, fy, fz;
    logic signed [65:0]   cr [3];
    logic        [65:0]   mag [3];
    logic        [65:0]   big;
    longint unsigned      v [3];
    longint unsigned      sum, r, q;
    int                   len;
    ex = 64'(t.b_x) - 64'(t.a_x);
    ey = 64'(t.b_y) - 64'(t.a_y);
    ez = 64'(t.b_z) - 64'(t.a_z);
    fx = 64'(t.c_x) - 64'(t.a_x);
    fy = 64'(t.c_y) - 64'(t.a_y);
    fz = 64'(t.c_z) - 64'(t.a_z);
    cr[0] = 66'(ey * fz) - 66'(ez * fy);
    cr[1] = 66'(ez * fx) - 66'(ex * fz);
    cr[2] = 66'(ex * fy) - 66'(ey * fx);
    big = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = cr[i] < 0 ? 66'(-cr[i]) : 66'(cr[i]);
      if (mag[i] > big) big = mag[i];
    end
    res = '0;
    if (big == 0) begin
      res.degenerate = 1'b1;
      return res;
    end
    len = 0;
    for (int i = 0; i < 66; i++) if (big[i]) len = i + 1;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      if (len > 30) v[i] = 64'(mag[i] >> (len - 30));
      else v[i] = 64'(mag[i] << (30 - len));
      sum = sum + v[i] * v[i];
    end
    r = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((v[i] << (tfn_pkg::FB + 1)) + r) / (r << 1);
      if (cr[i] < 0) q = -q;
      if (i == 0) res.normal_x = q[15:0];
      else if (i == 1) res.normal_y = q[15:0];
      else res.normal_z = q[15:0];
    end
    return res;
  endfunction

  function void note_triangle(tfn_pkg::tfn_in_t t);
    pending_normals.push_back(face_normal(t));
  endfunction

  task report(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  task check_normal(tfn_pkg::tfn_out_t got);
    tfn_pkg::tfn_out_t exp_n;
    if (pending_normals.size() == 0) begin
      report($sformatf("unexpected result %h", got));
      return;
    end
    exp_n = pending_normals.pop_front();
    if (got.normal_x !== exp_n.normal_x)
      report($sformatf("normal_x got %h want %h", got.normal_x, exp_n.normal_x));
    if (got.normal_y !== exp_n.normal_y)
      report($sformatf("normal_y got %h want %h", got.normal_y, exp_n.normal_y));
    if (got.normal_z !== exp_n.normal_z)
      report($sformatf("normal_z got %h want %h", got.normal_z, exp_n.normal_z));
    if (got.degenerate !== exp_n.degenerate)
      report($sformatf("degenerate got %b want %b", got.degenerate, exp_n.degenerate));
  endtask
endclass

module tb_triangle_face_normal;
  import tfn_pkg::*;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  tfn_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  tfn_out_t out_data;

  normal_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_off = 1'b0;

  triangle_face_normal u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Monitor both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_triangle(in_data);
    if (rst_n && out_valid && out_ready) sb.check_normal(out_data);
  end

  // Receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (!rst_n || hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [CB-1:0] rand_coord(int mode);
    case (mode)
      0: return CB'($urandom);
      1: return CB'($urandom_range(255)) - CB'(128);
      default: return CB'({$urandom} >> (8 + $urandom_range(15)))
                      ^ ({CB{1'($urandom_range(1))}});
    endcase
  endfunction

  function automatic tfn_in_t rand_triangle();
    tfn_in_t t;
    int mode, kind;
    mode = $urandom_range(2);
    t = {rand_coord(mode), rand_coord(mode), rand_coord(mode),
         rand_coord(mode), rand_coord(mode), rand_coord(mode),
         rand_coord(mode), rand_coord(mode), rand_coord(mode)};
    kind = $urandom_range(19);
    // occasional coincident or collinear vertices
    if (kind == 0) begin
      t.b_x = t.a_x; t.b_y = t.a_y; t.b_z = t.a_z;
    end else if (kind == 1) begin
      t.c_x = t.b_x + (t.b_x - t.a_x);
      t.c_y = t.b_y + (t.b_y - t.a_y);
      t.c_z = t.b_z + (t.b_z - t.a_z);
    end
    return t;
  endfunction

  // Offer one triangle and hold it until transfer
  task automatic send_triangle(tfn_in_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_phase(int n, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send_triangle(rand_triangle());
    in_valid <= 1'b0;
  endtask

  task automatic directed();
    localparam logic [CB-1:0] MAXC = {1'b0, {(CB-1){1'b1}}};
    localparam logic [CB-1:0] MINC = {1'b1, {(CB-1){1'b0}}};
    tfn_in_t t;
    // unit axes and both orientations
    send_triangle({72'd0, CB'(1), 48'd0, 24'd0, CB'(1), 24'd0});
    send_triangle({72'd0, 24'd0, CB'(1), 24'd0, CB'(1), 48'd0});
    send_triangle({72'd0, 48'd0, CB'(1), CB'(1), 48'd0});
    // all points equal, zero and extremes
    send_triangle('0);
    send_triangle({9{MAXC}});
    send_triangle({9{MINC}});
    // largest edges and cross products
    send_triangle({MINC, MINC, MINC, MAXC, MINC, MINC, MINC, MAXC, MINC});
    send_triangle({MINC, MINC, MINC, MAXC, MAXC, MINC, MINC, MAXC, MAXC});
    send_triangle({MAXC, MAXC, MAXC, MINC, MAXC, MAXC, MAXC, MINC, MAXC});
    send_triangle({MINC, MAXC, MINC, MAXC, MINC, MAXC, MINC, MINC, MAXC});
    // collinear
    send_triangle({CB'(0), CB'(0), CB'(0), CB'(5), CB'(7), CB'(9),
                   CB'(10), CB'(14), CB'(18)});
    // diagonal, rounding at equal components
    send_triangle({CB'(0), CB'(0), CB'(0), CB'(1), CB'(-1), CB'(0),
                   CB'(0), CB'(1), CB'(-1)});
    send_triangle({CB'(3), CB'(-2), CB'(7), CB'(-9), CB'(4), CB'(1),
                   CB'(6), CB'(11), CB'(-5)});
    for (int i = 0; i < 6; i++) begin
      t = rand_triangle();
      t.a_x = t.a_x ^ {CB{1'b1}};
      send_triangle(t);
    end
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    while (sb.pending_normals.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (80) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed();
    send_phase(300, 0, 0);
    // long receiver hold-off while triangles keep coming
    fork
      begin
        hold_off = 1'b1;
        for (int n = 0; n < 400; n++) @(posedge clk);
        hold_off = 1'b0;
      end
      send_phase(150, 0, 0);
    join
    send_phase(250, 72, 0);
    send_phase(250, 0, 72);
    send_phase(200, 22, 22);
    send_phase(100, 0, 0);
    recv_stall_pct = 0;
    drain();
    if (sb.errors == 0 && sb.pending_normals.size() == 0) begin
      $display("triangle_face_normal regression: pass");
    end else begin
      if (sb.pending_normals.size() != 0) sb.report("results missing at end");
      $display("triangle_face_normal regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("triangle_face_normal regression: fail");
    $finish;
  end
endmodule
